[design/weighted_running_median_bank_top_assert.svh]
// Assertion macros for the median bank checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef WEIGHTED_RUNNING_MEDIAN_BANK_TOP_ASSERT_SVH
`define WEIGHTED_RUNNING_MEDIAN_BANK_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WRMB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WRMB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/wrmb_pkg.sv]
package wrmb_pkg;

	// Width of the sample and result fields on the channels.
	localparam int IO_W = 32;

	localparam logic ACT_FILTER  = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WSTART,
		ST_UP,
		ST_DN,
		ST_PUT,
		ST_MED,
		ST_ACC,
		ST_DIV,
		ST_DONE
	} wrmb_state_t;

	typedef struct packed {
		logic wr;
		logic clear;
	} wrmb_store_ctl_t;

endpackage

[design/wrmb_if.sv]
interface wrmb_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [wrmb_pkg::IO_W-1:0]  sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink   (input valid, input action, input sample, output ready);
endinterface

interface wrmb_out_if;
	logic                       valid;
	logic                       ready;
	logic [wrmb_pkg::IO_W-1:0]  filtered;

	modport source (output valid, output filtered, input ready);
	modport sink   (input valid, input filtered, output ready);
endinterface

[design/wrmb_store.sv]
module wrmb_store #(
	parameter int DEPTH  = 33,
	parameter int DATA_W = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wrmb_pkg::wrmb_store_ctl_t   ctl,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [DATA_W-1:0]           wr_data,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	input  logic [DATA_W-1:0]           fill_data,
	output logic [DATA_W-1:0]           rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic              rvld_q;
	logic [DEPTH-1:0]  vld_q;
	logic [DATA_W-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// An entry that was not written since the last clear reads as the fill value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
			fill_q <= '0;
		end else begin
			rvld_q <= vld_q[rd_addr];
			if (ctl.clear) begin
				vld_q  <= '0;
				fill_q <= fill_data;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rvld_q ? rd_q : fill_q;

endmodule

[design/weighted_running_median_bank_top.sv]
// Weighted running median bank. FILTER_LENGTH-2 sorted windows of lengths
// FILTER_LENGTH down to 3 share one store; each new sample replaces the entry at
// its window's slot cursor and is bubbled into place, and the result is the sum of
// window medians weighted by powers of two, divided by 2^(FILTER_LENGTH-2)-1 with
// rounding to nearest. A restart transaction fills every window with the sample and
// presents it as the result via the DONE state and the output register. A filter
// transaction visits each window in turn: it probes a neighbor of the cursor slot,
// moves the sample up or down one place per step, writes it, reads the median and
// adds it to the sum; when the upward probe fails at a slot that has a lower
// neighbor, a downward probe follows. The division then folds the high part of the
// sum into the quotient once per cycle until the rest is below 2^(FILTER_LENGTH-2),
// and the DONE state loads the output. The input is ready again once the result has
// been placed in the output register, which holds it until it is taken, so a waiting
// result delays that load.
module weighted_running_median_bank_top #(
	parameter int FILTER_LENGTH = 8,
	parameter int SAMPLE_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	wrmb_in_if.sink     samples,
	wrmb_out_if.source  results
);

	localparam int NW    = FILTER_LENGTH - 2;
	localparam int SD    = FILTER_LENGTH * (FILTER_LENGTH + 1) / 2 - 3;
	localparam int AA    = $clog2(SD);
	localparam int PW    = $clog2(FILTER_LENGTH);
	localparam int LW    = $clog2(FILTER_LENGTH + 1);
	localparam int WW    = $clog2(NW);
	localparam int DW    = NW + 1;
	localparam int ACCW  = SAMPLE_WIDTH + NW + 1;
	localparam int OW    = wrmb_pkg::IO_W;
	localparam int HALF_D = ((1 << NW) - 2) / 2;
	localparam logic [DW-1:0] DIVISOR = DW'((1 << NW) - 1);
	// Offset that keeps the sum positive and adds half the divisor for rounding.
	localparam logic [ACCW-1:0] BIAS =
		(ACCW'(DIVISOR) << (SAMPLE_WIDTH - 1)) + ACCW'(HALF_D);
	localparam logic [SAMPLE_WIDTH-1:0] SIGN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

	wrmb_pkg::wrmb_state_t st_q, st_d;
	wrmb_pkg::wrmb_store_ctl_t ctl;

	logic [SAMPLE_WIDTH-1:0] smp;
	logic [SAMPLE_WIDTH-1:0] val_q;
	logic [WW-1:0]           w_q;
	logic [AA-1:0]           base_q;
	logic [LW-1:0]           len_q;
	logic [PW-1:0]           pos_q;
	logic                    first_q;
	logic [PW-1:0]           cur_q [NW];
	logic [ACCW-1:0]         acc_q;
	logic [ACCW-1:0]         q_q;
	logic                    out_vld_q;
	logic [OW-1:0]           out_q;

	logic [AA-1:0]           wr_addr, rd_addr;
	logic [SAMPLE_WIDTH-1:0] wr_data, rdv;
	logic [PW-1:0]           cur_raw, cur_ok, last_pos;
	logic [AA-1:0]           a_pos, a_cur;
	logic                    up_gt, dn_gt;
	logic                    accept, load_out;
	logic [ACCW-1:0]         div_t, div_step;
	logic [ACCW-1:0]         term;
	logic [SAMPLE_WIDTH-1:0] res;

	assign smp      = SAMPLE_WIDTH'(samples.sample);
	assign accept   = samples.valid && samples.ready;
	assign samples.ready = (st_q == wrmb_pkg::ST_IDLE);

	assign cur_raw  = cur_q[w_q];
	assign cur_ok   = (LW'(cur_raw) < len_q) ? cur_raw : '0;
	assign last_pos = PW'(len_q - LW'(1));
	assign a_pos    = base_q + AA'(pos_q);
	assign a_cur    = base_q + AA'(cur_ok);
	assign up_gt    = $signed(val_q) > $signed(rdv);
	assign dn_gt    = $signed(rdv) > $signed(val_q);

	assign term   = ACCW'({{(NW + 1){rdv[SAMPLE_WIDTH-1]}}, rdv}) << w_q;
	assign div_t  = acc_q >> NW;
	// Once the rest is below 2^NW it can still equal the divisor, which adds one more to the quotient.
	assign div_step = (div_t != '0) ? div_t :
		{{(ACCW - 1){1'b0}}, acc_q == ACCW'(DIVISOR)};
	assign res    = q_q[SAMPLE_WIDTH-1:0] ^ SIGN;
	assign load_out = (st_q == wrmb_pkg::ST_DONE) && (!out_vld_q || results.ready);

	wrmb_store #(
		.DEPTH (SD),
		.DATA_W(SAMPLE_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.fill_data(smp),
		.rd_data  (rdv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= wrmb_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Sequencer: probe the neighbor, carry the new sample up or down one slot per cycle
	// while the next read is already under way, then read the median, accumulate it and divide.
	always_comb begin
		st_d      = st_q;
		ctl       = '0;
		wr_addr   = a_pos;
		wr_data   = val_q;
		rd_addr   = '0;
		case (st_q)
			wrmb_pkg::ST_IDLE: begin
				if (accept) begin
					if (samples.action == wrmb_pkg::ACT_RESTART) begin
						ctl.clear = 1'b1;
						st_d      = wrmb_pkg::ST_DONE;
					end else begin
						st_d = wrmb_pkg::ST_WSTART;
					end
				end
			end
			wrmb_pkg::ST_WSTART: begin
				if (cur_ok < last_pos) begin
					rd_addr = a_cur + AA'(1);
					st_d    = wrmb_pkg::ST_UP;
				end else if (cur_ok != '0) begin
					rd_addr = a_cur - AA'(1);
					st_d    = wrmb_pkg::ST_DN;
				end else begin
					st_d = wrmb_pkg::ST_PUT;
				end
			end
			wrmb_pkg::ST_UP: begin
				if (up_gt) begin
					ctl.wr  = 1'b1;
					wr_data = rdv;
					if ((pos_q + PW'(1)) < last_pos) begin
						rd_addr = a_pos + AA'(2);
					end else begin
						st_d = wrmb_pkg::ST_PUT;
					end
				end else if (first_q && pos_q != '0) begin
					rd_addr = a_pos - AA'(1);
					st_d    = wrmb_pkg::ST_DN;
				end else begin
					ctl.wr = 1'b1;
					st_d   = wrmb_pkg::ST_MED;
				end
			end
			wrmb_pkg::ST_DN: begin
				if (dn_gt) begin
					ctl.wr  = 1'b1;
					wr_data = rdv;
					if (pos_q != PW'(1)) begin
						rd_addr = a_pos - AA'(2);
					end else begin
						st_d = wrmb_pkg::ST_PUT;
					end
				end else begin
					ctl.wr = 1'b1;
					st_d   = wrmb_pkg::ST_MED;
				end
			end
			wrmb_pkg::ST_PUT: begin
				ctl.wr = 1'b1;
				st_d   = wrmb_pkg::ST_MED;
			end
			wrmb_pkg::ST_MED: begin
				rd_addr = base_q + AA'(len_q >> 1);
				st_d    = wrmb_pkg::ST_ACC;
			end
			wrmb_pkg::ST_ACC: begin
				if (w_q == WW'(NW - 1)) begin
					st_d = wrmb_pkg::ST_DIV;
				end else begin
					st_d = wrmb_pkg::ST_WSTART;
				end
			end
			wrmb_pkg::ST_DIV: begin
				if (div_t == '0) begin
					st_d = wrmb_pkg::ST_DONE;
				end
			end
			wrmb_pkg::ST_DONE: begin
				if (load_out) begin
					st_d = wrmb_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = wrmb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) begin
				cur_q[i] <= '0;
			end
			out_vld_q <= 1'b0;
		end else begin
			if (st_q == wrmb_pkg::ST_IDLE && accept &&
				samples.action == wrmb_pkg::ACT_RESTART) begin
				for (int i = 0; i < NW; i++) begin
					cur_q[i] <= '0;
				end
			end else if (st_q == wrmb_pkg::ST_ACC) begin
				cur_q[w_q] <= (cur_ok == last_pos) ? '0 : cur_ok + PW'(1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			wrmb_pkg::ST_IDLE: begin
				val_q   <= smp;
				w_q     <= '0;
				base_q  <= '0;
				len_q   <= LW'(FILTER_LENGTH);
				acc_q   <= BIAS;
				q_q     <= (samples.action == wrmb_pkg::ACT_RESTART) ?
					ACCW'(smp ^ SIGN) : '0;
			end
			wrmb_pkg::ST_WSTART: begin
				pos_q   <= cur_ok;
				first_q <= 1'b1;
			end
			wrmb_pkg::ST_UP: begin
				first_q <= 1'b0;
				if (up_gt) begin
					pos_q <= pos_q + PW'(1);
				end
			end
			wrmb_pkg::ST_DN: begin
				if (dn_gt) begin
					pos_q <= pos_q - PW'(1);
				end
			end
			wrmb_pkg::ST_ACC: begin
				acc_q  <= acc_q + term;
				w_q    <= w_q + WW'(1);
				base_q <= base_q + AA'(len_q);
				len_q  <= len_q - LW'(1);
			end
			wrmb_pkg::ST_DIV: begin
				// Since 2^NW is one more than the divisor, the part from bit NW up goes
				// to the quotient and is added back into the low bits.
				q_q   <= q_q + div_step;
				acc_q <= div_t + (acc_q & ACCW'(DIVISOR));
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_q <= OW'(res);
		end
	end

	assign results.valid    = out_vld_q;
	assign results.filtered = out_q;

endmodule

[design/wrmb_checker.sv]
`include "weighted_running_median_bank_top_assert.svh"

module wrmb_checker #(
	parameter int SAMPLE_WIDTH = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_action,
	input logic [wrmb_pkg::IO_W-1:0]  in_sample,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [wrmb_pkg::IO_W-1:0]  out_filtered
);

	localparam int KW = (SAMPLE_WIDTH < wrmb_pkg::IO_W) ? SAMPLE_WIDTH : wrmb_pkg::IO_W;
	localparam logic [wrmb_pkg::IO_W-1:0] MASK = wrmb_pkg::IO_W'((64'd1 << KW) - 64'd1);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	`WRMB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
		"result dropped while stalled")
	`WRMB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_filtered),
		"result changed while stalled")
	`WRMB_ASSERT_NEXT(a_busy, in_acc, !in_ready,
		"input taken again while a transaction is in progress")
	`WRMB_ASSERT_SAME(a_restart_echo,
		$past(in_acc, 2) && $past(in_action, 2) == wrmb_pkg::ACT_RESTART &&
		!$past(out_valid, 2) && !$past(out_valid, 1),
		out_valid && ((out_filtered ^ $past(in_sample, 2)) & MASK) == '0,
		"restart did not return its sample")

endmodule

bind weighted_running_median_bank_top wrmb_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_wrmb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.in_action   (samples.action),
	.in_sample   (samples.sample),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_filtered(results.filtered)
);
